FILE: rtl/ssfb_pkg.sv
// Types, constants and the microcode table of the seven-segment frame builder.
package ssfb_pkg;

  // Input item and result item as they travel on the channels.
  typedef struct packed {
    logic signed [31:0] value;
    logic               blink_phase;
    logic [3:0]         brightness_level;
  } ssfb_in_t;

  typedef struct packed {
    logic [15:0] frame_word;
    logic        last_word;
  } ssfb_out_t;

  // Configuration register indexes (byte address bits [3:2]).
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_SCAN_LIMIT     = 2'd0;
  localparam reg_idx_t REG_DECODE_MODE    = 2'd1;
  localparam reg_idx_t REG_POINT_POSITION = 2'd2;
  localparam reg_idx_t REG_BLINK_ENABLE   = 2'd3;

  // Reset values of the configuration registers and the held state.
  localparam logic [2:0] SCAN_LIMIT_RST     = 3'd4;
  localparam logic [7:0] DECODE_MODE_RST    = 8'hFF;
  localparam logic [3:0] POINT_POSITION_RST = 4'd5;
  localparam logic       BLINK_ENABLE_RST   = 1'b0;
  localparam logic [3:0] BRIGHTNESS_RST     = 4'hF;

  localparam logic [15:0] DIGIT_RESET [8] = '{
    16'h0505, 16'h0404, 16'h0303, 16'h0208, 16'h0109, 16'h0000, 16'h0000, 16'h0000
  };

  // Frame layout.
  localparam int unsigned HEADER_WORDS = 5;
  localparam int unsigned MINUS_INDEX  = 4;

  // Header command words; low byte is filled in where the word carries data.
  localparam logic [15:0] CMD_SHUTDOWN  = 16'h0C01;
  localparam logic [15:0] CMD_DECODE    = 16'h0900;
  localparam logic [15:0] CMD_TEST      = 16'h0F00;
  localparam logic [15:0] CMD_INTENSITY = 16'h0A00;
  localparam logic [15:0] CMD_SCAN      = 16'h0B00;

  // Digit data codes.
  localparam logic [7:0] DECODE_FULL  = 8'hFF;
  localparam logic [7:0] POINT_BIT    = 8'h80;
  localparam logic [3:0] BLANK_NIBBLE = 4'hF;
  localparam logic [3:0] MINUS_NIBBLE = 4'hA;
  localparam logic [7:0] BLINK_DATA   = 8'h0F;

  // Division by ten as a multiply by the rounded-up reciprocal 2^35/10, exact for 32 bits.
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int unsigned DIV10_SHIFT = 35;

  // Sequencer step addresses.
  typedef logic [3:0] pc_t;
  localparam pc_t STEP_IDLE  = 4'd0;
  localparam pc_t STEP_DIV   = 4'd1;
  localparam pc_t STEP_DWR   = 4'd2;
  localparam pc_t STEP_PTSEL = 4'd3;
  localparam pc_t STEP_PTSET = 4'd4;
  localparam pc_t STEP_BLANK = 4'd5;
  localparam pc_t STEP_MSEL  = 4'd6;
  localparam pc_t STEP_MSET  = 4'd7;
  localparam pc_t STEP_BSEL  = 4'd8;
  localparam pc_t STEP_BLNK  = 4'd9;
  localparam pc_t STEP_HDR   = 4'd10;
  localparam pc_t STEP_DIG   = 4'd11;
  localparam pc_t STEP_DONE  = 4'd12;

  // Datapath operation of one step.
  typedef enum logic [3:0] {
    OP_ACCEPT,
    OP_DIV,
    OP_DWR,
    OP_PTSEL,
    OP_PTSET,
    OP_BLANK,
    OP_MSEL,
    OP_MSET,
    OP_IDX0,
    OP_BLNK,
    OP_EMIT_HDR,
    OP_EMIT_DIG,
    OP_NOP
  } op_t;

  // Jump condition of one step; when it holds the step jumps to its target.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_DECODE,
    C_MORE_DIGITS,
    C_NO_POINT,
    C_NO_BLANK,
    C_BLANK_MORE,
    C_NOT_NEG,
    C_NO_BLINK_OFF,
    C_MORE_HDR
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  // Control store: one control word per step.
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t uw;
    case (pc)
      STEP_IDLE:  uw = '{OP_ACCEPT,   C_NO_DECODE,    STEP_HDR};
      STEP_DIV:   uw = '{OP_DIV,      C_NEVER,        STEP_DWR};
      STEP_DWR:   uw = '{OP_DWR,      C_MORE_DIGITS,  STEP_DIV};
      STEP_PTSEL: uw = '{OP_PTSEL,    C_NO_POINT,     STEP_MSEL};
      STEP_PTSET: uw = '{OP_PTSET,    C_NO_BLANK,     STEP_MSEL};
      STEP_BLANK: uw = '{OP_BLANK,    C_BLANK_MORE,   STEP_BLANK};
      STEP_MSEL:  uw = '{OP_MSEL,     C_NOT_NEG,      STEP_BSEL};
      STEP_MSET:  uw = '{OP_MSET,     C_NEVER,        STEP_BSEL};
      STEP_BSEL:  uw = '{OP_IDX0,     C_NO_BLINK_OFF, STEP_HDR};
      STEP_BLNK:  uw = '{OP_BLNK,     C_MORE_DIGITS,  STEP_BLNK};
      STEP_HDR:   uw = '{OP_EMIT_HDR, C_MORE_HDR,     STEP_HDR};
      STEP_DIG:   uw = '{OP_EMIT_DIG, C_MORE_DIGITS,  STEP_DIG};
      STEP_DONE:  uw = '{OP_NOP,      C_ALWAYS,       STEP_IDLE};
      default:    uw = '{OP_NOP,      C_ALWAYS,       STEP_IDLE};
    endcase
    return uw;
  endfunction

endpackage

FILE: rtl/seven_segment_frame_builder.sv
// Microcoded builder of 7-segment driver command frames, with APB configuration.
// Sequence: an accept step, then with full decode a digit-generation pair per digit
// (multiply by the reciprocal of ten, then the digit write), fix-up steps for point,
// blanking, minus sign and blink, the header and digit output steps and one return step.
// With decode off, the accept step goes straight to the header. Output stalls hold the output steps.
// Throughput: one refresh at a time; the next item is taken once the last word is in the output register.
// Reset (rst_n low, synchronous): registers to defaults, digit words to their reset
// pattern, held brightness to 15, sequencer at its idle step, no result pending.
module seven_segment_frame_builder #(
  parameter int unsigned MAX_DIGITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ssfb_pkg::ssfb_in_t   in_data,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output ssfb_pkg::ssfb_out_t  out_data,
  // Configuration port
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [3:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int unsigned IDX_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [2:0]  SCAN_MAX  = 3'(MAX_DIGITS - 1);
  localparam logic [3:0]  POINT_MAX = 4'(MAX_DIGITS);
  localparam logic        HAS_MINUS = (MAX_DIGITS > ssfb_pkg::MINUS_INDEX);
  localparam logic [4:0]  HDR_LAST  = 5'(ssfb_pkg::HEADER_WORDS - 1);

  // Configuration and held state.
  logic [2:0] scan_limit_r;
  logic [7:0] decode_mode_r;
  logic [3:0] point_position_r;
  logic       blink_enable_r;
  logic [3:0] held_bright_r, held_bright_nxt;

  // Sequencer and datapath registers.
  ssfb_pkg::pc_t pc_r, pc_nxt;
  logic [31:0]      mag_r, mag_nxt;
  logic [31:0]      quo_r, quo_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             neg_r, neg_nxt;
  logic             phase_r, phase_nxt;
  logic [15:0]      digit_r [MAX_DIGITS];

  logic                out_valid_r, out_valid_nxt;
  ssfb_pkg::ssfb_out_t out_item_r, out_item_nxt;

  ssfb_pkg::ucode_t uw;
  logic             cond_hit;
  logic             advance;
  logic             out_free;
  logic             in_fire;
  logic             cfg_write;

  logic [2:0]       scan3;
  logic [IDX_W-1:0] scan_idx;
  logic [3:0]       idx4;
  logic [3:0]       point_sum;
  logic [3:0]       blank_lo;
  logic             point_ok;
  logic [15:0]      rd_word;
  logic             wr_en;
  logic [15:0]      wr_word;
  logic [63:0]      div_prod;
  logic [3:0]       div_rem;
  logic [31:0]      in_mag;
  logic [7:0]       digit_addr;

  // Register write decode; the port never waits.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_limit_r     <= ssfb_pkg::SCAN_LIMIT_RST;
      decode_mode_r    <= ssfb_pkg::DECODE_MODE_RST;
      point_position_r <= ssfb_pkg::POINT_POSITION_RST;
      blink_enable_r   <= ssfb_pkg::BLINK_ENABLE_RST;
    end else if (cfg_write) begin
      case (ssfb_pkg::reg_idx_t'(cfg_paddr[3:2]))
        ssfb_pkg::REG_SCAN_LIMIT:     scan_limit_r     <= cfg_pwdata[2:0];
        ssfb_pkg::REG_DECODE_MODE:    decode_mode_r    <= cfg_pwdata[7:0];
        ssfb_pkg::REG_POINT_POSITION: point_position_r <= cfg_pwdata[3:0];
        ssfb_pkg::REG_BLINK_ENABLE:   blink_enable_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read mux.
  always_comb begin
    case (ssfb_pkg::reg_idx_t'(cfg_paddr[3:2]))
      ssfb_pkg::REG_SCAN_LIMIT:     cfg_prdata = {29'd0, scan_limit_r};
      ssfb_pkg::REG_DECODE_MODE:    cfg_prdata = {24'd0, decode_mode_r};
      ssfb_pkg::REG_POINT_POSITION: cfg_prdata = {28'd0, point_position_r};
      ssfb_pkg::REG_BLINK_ENABLE:   cfg_prdata = {31'd0, blink_enable_r};
      default:                      cfg_prdata = 32'd0;
    endcase
  end

  // Derived limits: clamped scan, point validity and the lowest digit that may blank.
  always_comb begin
    scan3     = (scan_limit_r > SCAN_MAX) ? SCAN_MAX : scan_limit_r;
    scan_idx  = IDX_W'(scan3);
    idx4      = 4'(idx_r);
    point_ok  = (point_position_r != 4'd0) && (point_position_r <= POINT_MAX);
    point_sum = {1'b0, scan3} + point_position_r;
    blank_lo  = (point_sum < 4'd4) ? 4'd0 : (point_sum - 4'd4);
  end

  // Single read port of the digit store.
  assign rd_word = digit_r[idx_r];

  // Quotient by ten from a 32 by 32 product; the remainder needs only the low four bits.
  assign div_prod = 64'(mag_r) * 64'(ssfb_pkg::DIV10_MAGIC);
  assign div_rem  = mag_r[3:0] - {quo_r[0], 3'b000} - {quo_r[2:0], 1'b0};

  assign in_mag = in_data.value[31] ? (32'd0 - in_data.value) : in_data.value;
  assign digit_addr = {5'd0, scan3} + 8'd1 - 8'(idx_r);

  // Control word of the current step.
  assign uw = ssfb_pkg::ucode_rom(pc_r);

  // Jump condition.
  always_comb begin
    case (uw.cond)
      ssfb_pkg::C_NEVER:        cond_hit = 1'b0;
      ssfb_pkg::C_ALWAYS:       cond_hit = 1'b1;
      ssfb_pkg::C_NO_DECODE:    cond_hit = (decode_mode_r != ssfb_pkg::DECODE_FULL);
      ssfb_pkg::C_MORE_DIGITS:  cond_hit = (idx_r != scan_idx);
      ssfb_pkg::C_NO_POINT:     cond_hit = !point_ok;
      ssfb_pkg::C_NO_BLANK:     cond_hit = (blank_lo > {1'b0, scan3});
      ssfb_pkg::C_BLANK_MORE:   cond_hit = (rd_word[3:0] == 4'd0) && (idx4 != blank_lo);
      ssfb_pkg::C_NOT_NEG:      cond_hit = !(neg_r && HAS_MINUS);
      ssfb_pkg::C_NO_BLINK_OFF: cond_hit = !(blink_enable_r && !phase_r);
      ssfb_pkg::C_MORE_HDR:     cond_hit = (cnt_r != HDR_LAST);
      default:                  cond_hit = 1'b1;
    endcase
  end

  // Stall on an empty input or a full output register.
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (uw.op == ssfb_pkg::OP_ACCEPT);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    case (uw.op)
      ssfb_pkg::OP_ACCEPT:   advance = in_valid;
      ssfb_pkg::OP_EMIT_HDR: advance = out_free;
      ssfb_pkg::OP_EMIT_DIG: advance = out_free;
      default:               advance = 1'b1;
    endcase
  end

  // Step counter: jump, fall through or hold.
  always_comb begin
    if (!advance) begin
      pc_nxt = pc_r;
    end else if (cond_hit) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + 4'd1;
    end
  end

  // Datapath actions of the current step.
  always_comb begin
    mag_nxt         = mag_r;
    quo_nxt         = quo_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    neg_nxt         = neg_r;
    phase_nxt       = phase_r;
    held_bright_nxt = held_bright_r;
    wr_en           = 1'b0;
    wr_word         = rd_word;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_item_nxt    = out_item_r;
    case (uw.op)
      ssfb_pkg::OP_ACCEPT: begin
        if (in_fire) begin
          mag_nxt   = in_mag;
          neg_nxt   = in_data.value[31];
          phase_nxt = in_data.blink_phase;
          cnt_nxt   = 5'd0;
          idx_nxt   = '0;
          if (!blink_enable_r) begin
            held_bright_nxt = in_data.brightness_level;
          end
        end
      end
      ssfb_pkg::OP_DIV: begin
        quo_nxt = {3'd0, div_prod[63:ssfb_pkg::DIV10_SHIFT]};
      end
      ssfb_pkg::OP_DWR: begin
        wr_en   = 1'b1;
        wr_word = {digit_addr, 4'd0, div_rem};
        mag_nxt = quo_r;
        idx_nxt = idx_r + 1'b1;
      end
      ssfb_pkg::OP_PTSEL: begin
        idx_nxt = IDX_W'(point_position_r - 4'd1);
      end
      ssfb_pkg::OP_PTSET: begin
        wr_en   = 1'b1;
        wr_word = rd_word | {8'd0, ssfb_pkg::POINT_BIT};
        idx_nxt = scan_idx;
      end
      ssfb_pkg::OP_BLANK: begin
        wr_en   = (rd_word[3:0] == 4'd0);
        wr_word = {rd_word[15:4], ssfb_pkg::BLANK_NIBBLE};
        idx_nxt = idx_r - 1'b1;
      end
      ssfb_pkg::OP_MSEL: begin
        idx_nxt = IDX_W'(ssfb_pkg::MINUS_INDEX);
      end
      ssfb_pkg::OP_MSET: begin
        wr_en   = 1'b1;
        wr_word = {rd_word[15:4], ssfb_pkg::MINUS_NIBBLE};
      end
      ssfb_pkg::OP_IDX0: begin
        idx_nxt = '0;
      end
      ssfb_pkg::OP_BLNK: begin
        wr_en   = 1'b1;
        wr_word = {rd_word[15:8], ssfb_pkg::BLINK_DATA};
        idx_nxt = idx_r + 1'b1;
      end
      ssfb_pkg::OP_EMIT_HDR: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.last_word = 1'b0;
          case (cnt_r)
            5'd0:    out_item_nxt.frame_word = ssfb_pkg::CMD_SHUTDOWN;
            5'd1:    out_item_nxt.frame_word = ssfb_pkg::CMD_DECODE | {8'd0, decode_mode_r};
            5'd2:    out_item_nxt.frame_word = ssfb_pkg::CMD_TEST;
            5'd3:    out_item_nxt.frame_word = ssfb_pkg::CMD_INTENSITY
                                               | {12'd0, held_bright_r};
            default: out_item_nxt.frame_word = ssfb_pkg::CMD_SCAN | {13'd0, scan3};
          endcase
          cnt_nxt = cnt_r + 5'd1;
          idx_nxt = '0;
        end
      end
      ssfb_pkg::OP_EMIT_DIG: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.frame_word = rd_word;
          out_item_nxt.last_word  = (idx_r == scan_idx);
          idx_nxt                 = idx_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r          <= ssfb_pkg::STEP_IDLE;
      out_valid_r   <= 1'b0;
      held_bright_r <= ssfb_pkg::BRIGHTNESS_RST;
      cnt_r         <= 5'd0;
      idx_r         <= '0;
    end else begin
      pc_r          <= pc_nxt;
      out_valid_r   <= out_valid_nxt;
      held_bright_r <= held_bright_nxt;
      cnt_r         <= cnt_nxt;
      idx_r         <= idx_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    quo_r      <= quo_nxt;
    neg_r      <= neg_nxt;
    phase_r    <= phase_nxt;
    out_item_r <= out_item_nxt;
  end

  // Digit word store, one write port at the shared index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digit_r[i] <= ssfb_pkg::DIGIT_RESET[i];
      end
    end else if (wr_en) begin
      digit_r[idx_r] <= wr_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // A new refresh starts only once the previous frame's last word has reached the output register.
  a_accept_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (!out_valid_r || out_item_r.last_word))
    else $error("input accepted while a frame is still being sent");

  // At the digit write step, the division remainder always stays a decimal digit.
  a_rem_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ssfb_pkg::STEP_DWR) |-> (div_rem < 4'd10))
    else $error("division remainder out of range");

  // Digit output never runs past the scan limit.
  a_dig_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ssfb_pkg::STEP_DIG) |-> (idx_r <= scan_idx))
    else $error("digit index beyond scan limit");

  // Header output covers only the header words.
  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ssfb_pkg::STEP_HDR) |-> (cnt_r <= HDR_LAST))
    else $error("header counter beyond header length");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench of the seven-segment frame builder: refresh requests in, command words out.
module testbench;
  import ssfb_pkg::*;

  localparam int unsigned DIGITS     = 8;
  localparam int unsigned HOLD_LEN   = 2500;
  localparam int unsigned HOLD_AFTER = 600;
  localparam int unsigned DRAIN_WAIT = 400;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  ssfb_in_t    in_data     = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  ssfb_out_t   out_data;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  seven_segment_frame_builder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Shadow copy of the configuration and the display state.
  logic [2:0]  cfg_scan;
  logic [7:0]  cfg_decode;
  logic [3:0]  cfg_point;
  logic        cfg_blink;
  logic [15:0] digit_mem [DIGITS];
  logic [3:0]  held_bright;

  ssfb_in_t    refresh_q [$];
  ssfb_out_t   frame_q [$];
  int          n_queued    = 0;
  int          n_accepted  = 0;
  int          words_seen  = 0;
  int          err_count   = 0;

  // Sender pacing and receiver stall pattern.
  int          burst_left  = 0;
  int          gap_left    = 0;
  int          stall_tick  = 0;
  int          stall_mode  = 0;
  int          hold_left   = 0;
  bit          hold_done   = 1'b0;
  bit          next_ready;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_word(input logic [15:0] word, input logic last);
    ssfb_out_t w;
    w.frame_word = word;
    w.last_word  = last;
    frame_q.push_back(w);
  endfunction

  // Expected command words of one refresh; updates the shadow display state.
  function automatic void build_frame(input ssfb_in_t item);
    logic [31:0] raw;
    logic [31:0] mag;
    int          nscan;
    int          stop;
    int          n;
    raw   = item.value;
    nscan = cfg_scan;
    if (!cfg_blink) held_bright = item.brightness_level;
    if (cfg_decode == DECODE_FULL) begin
      mag = raw[31] ? (~raw + 32'd1) : raw;
      for (n = 0; n <= nscan; n++) begin
        digit_mem[n] = 16'((mag % 32'd10) | (32'(nscan + 1 - n) << 8));
        mag = mag / 32'd10;
      end
      // Decimal point, then leading-zero blanking from the top digit down.
      if (cfg_point >= 4'd1 && cfg_point <= 4'(DIGITS)) begin
        stop = nscan + int'(cfg_point) - 4;
        if (stop < 0) stop = 0;
        digit_mem[cfg_point - 4'd1][7:0] = digit_mem[cfg_point - 4'd1][7:0] | POINT_BIT;
        for (n = nscan; n >= stop; n--) begin
          if (digit_mem[n][3:0] == 4'd0) digit_mem[n][3:0] = BLANK_NIBBLE;
          else break;
        end
      end
      if (raw[31]) digit_mem[MINUS_INDEX][3:0] = MINUS_NIBBLE;
      if (cfg_blink && !item.blink_phase) begin
        for (n = 0; n <= nscan; n++) digit_mem[n][7:0] = BLINK_DATA;
      end
    end
    push_word(CMD_SHUTDOWN, 1'b0);
    push_word(CMD_DECODE | {8'd0, cfg_decode}, 1'b0);
    push_word(CMD_TEST, 1'b0);
    push_word(CMD_INTENSITY | {12'd0, held_bright}, 1'b0);
    push_word(CMD_SCAN | {13'd0, cfg_scan}, 1'b0);
    for (n = 0; n <= nscan; n++) push_word(digit_mem[n], n == nscan);
  endfunction

  // Register write: setup cycle, then access cycle; the write lands at the end of the access cycle.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_SCAN_LIMIT:     cfg_scan   = data[2:0];
      REG_DECODE_MODE:    cfg_decode = data[7:0];
      REG_POINT_POSITION: cfg_point  = data[3:0];
      default:            cfg_blink  = data[0];
    endcase
  endtask

  task automatic set_config(input int scan, input int decode, input int point, input int blink);
    write_reg(REG_SCAN_LIMIT, 32'(scan));
    write_reg(REG_DECODE_MODE, 32'(decode));
    write_reg(REG_POINT_POSITION, 32'(point));
    write_reg(REG_BLINK_ENABLE, 32'(blink));
  endtask

  task automatic queue_item(input logic signed [31:0] v, input logic phase, input logic [3:0] lvl);
    ssfb_in_t item;
    item.value            = v;
    item.blink_phase      = phase;
    item.brightness_level = lvl;
    refresh_q.push_back(item);
    n_queued++;
  endtask

  // Block until every queued request is taken and every expected word has arrived.
  task automatic wait_drained();
    while (n_accepted != n_queued || frame_q.size() != 0) @(posedge clk);
  endtask

  // Random display value: full range, small numbers, powers of ten and extremes.
  function automatic logic signed [31:0] rand_value();
    logic [31:0] v;
    int          k;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 999);
      2: v = -$urandom_range(0, 999);
      3: begin
        v = $urandom_range(1, 9);
        k = $urandom_range(0, 8);
        repeat (k) v = v * 32'd10;
        if ($urandom_range(0, 1)) v = -v;
      end
      4: begin
        case ($urandom_range(0, 4))
          0: v = 32'h0000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = 32'h7FFF_FFFF;
          3: v = 32'h8000_0000;
          default: v = 32'h0000_0001;
        endcase
      end
      default: v = $urandom | 32'h8000_0000;
    endcase
    return v;
  endfunction

  // Driver: offers queued requests in bursts with random gaps between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        build_frame(in_data);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (refresh_q.size() > 0) begin
          in_data  <= refresh_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each word transfer and drives the receiver stall pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_seen++;
        if (frame_q.size() == 0) begin
          $error("frame_word: expected none, actual %h", out_data.frame_word);
          err_count++;
        end else begin
          if (out_data.frame_word !== frame_q[0].frame_word) begin
            $error("frame_word: expected %h, actual %h",
                   frame_q[0].frame_word, out_data.frame_word);
            err_count++;
          end
          if (out_data.last_word !== frame_q[0].last_word) begin
            $error("last_word: expected %b, actual %b",
                   frame_q[0].last_word, out_data.last_word);
            err_count++;
          end
          void'(frame_q.pop_front());
        end
      end

      stall_tick++;
      if (stall_tick % 128 == 0) stall_mode = $urandom_range(0, 3);

      // One long hold-off while requests are still waiting, so the input backs up.
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (!hold_done && words_seen >= HOLD_AFTER && refresh_q.size() > 2) begin
        hold_done  = 1'b1;
        hold_left  = HOLD_LEN;
        next_ready = 1'b0;
      end else begin
        case (stall_mode)
          0:       next_ready = 1'b1;
          1:       next_ready = 1'($urandom_range(0, 1));
          2:       next_ready = (stall_tick % 6) < 4;
          default: next_ready = ($urandom_range(0, 9) == 0);
        endcase
      end
      out_ready <= next_ready;
    end
  end

  // Stimulus and end of run.
  initial begin
    int phase_idx;
    int dec_pick;
    int i;
    cfg_scan    = SCAN_LIMIT_RST;
    cfg_decode  = DECODE_MODE_RST;
    cfg_point   = POINT_POSITION_RST;
    cfg_blink   = BLINK_ENABLE_RST;
    held_bright = BRIGHTNESS_RST;
    for (i = 0; i < DIGITS; i++) digit_mem[i] = DIGIT_RESET[i];

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Decode off right after reset shows the stored reset pattern.
    set_config(int'(SCAN_LIMIT_RST), 0, int'(POINT_POSITION_RST), 0);
    queue_item(32'sd0, 1'b1, 4'd0);
    queue_item(-32'sd1, 1'b0, 4'd15);
    wait_drained();
    set_config(7, 0, 5, 0);
    queue_item(32'sh7FFF_FFFF, 1'b1, 4'd9);
    wait_drained();

    // Full decode, no point: extremes of the value range.
    set_config(7, 255, 0, 0);
    queue_item(32'sd0, 1'b1, 4'd1);
    queue_item(32'sd1, 1'b0, 4'd2);
    queue_item(-32'sd1, 1'b1, 4'd3);
    queue_item(32'sh7FFF_FFFF, 1'b1, 4'd14);
    queue_item(32'sh8000_0000, 1'b0, 4'd15);
    queue_item(32'sd12345678, 1'b1, 4'd7);
    queue_item(-32'sd5, 1'b1, 4'd8);
    wait_drained();

    // Point on the top digit, and on digit zero with a single digit shown.
    set_config(7, 255, 8, 0);
    queue_item(32'sd100, 1'b1, 4'd5);
    queue_item(32'sd0, 1'b1, 4'd6);
    queue_item(32'sd40000000, 1'b0, 4'd10);
    wait_drained();
    set_config(0, 255, 1, 0);
    queue_item(32'sd0, 1'b1, 4'd11);
    queue_item(32'sd7, 1'b0, 4'd12);
    queue_item(-32'sd3, 1'b1, 4'd13);
    wait_drained();

    // Blinking: off phase blanks digits, brightness stays frozen.
    set_config(3, 255, 3, 1);
    queue_item(32'sd1234, 1'b0, 4'd4);
    queue_item(32'sd1234, 1'b1, 4'd2);
    queue_item(-32'sd20, 1'b1, 4'd11);
    wait_drained();

    // Point position beyond the digit count, then decode off after decoding.
    set_config(5, 255, 12, 0);
    queue_item(32'sd0, 1'b1, 4'd3);
    queue_item(-32'sd7, 1'b1, 4'd8);
    wait_drained();
    set_config(7, 0, 5, 1);
    queue_item(32'sd55, 1'b0, 4'd6);
    wait_drained();
    set_config(2, 254, 4, 0);
    queue_item(32'sd9, 1'b1, 4'd1);
    wait_drained();

    // Random phases, each with its own register setting.
    for (phase_idx = 0; phase_idx < 12; phase_idx++) begin
      dec_pick = $urandom_range(0, 9);
      set_config($urandom_range(0, 7),
                 (dec_pick < 6) ? 255 : (dec_pick == 6) ? 0 : (dec_pick == 7) ? 254
                                      : $urandom_range(0, 255),
                 ($urandom_range(0, 4) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8),
                 $urandom_range(0, 1));
      for (i = 0; i < 17; i++) begin
        queue_item(rand_value(), 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      end
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: seven_segment_frame_builder.f
rtl/ssfb_pkg.sv
rtl/seven_segment_frame_builder.sv
tb/testbench.sv
